FILE: rtl/core/b58_pkg.sv
`timescale 1ns / 1ps
package b58_pkg;

  localparam int AccW = 256;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  version_byte;
    logic [31:0] hash_word_hi;
    logic [63:0] hash_word_mid;
    logic [63:0] hash_word_lo;
    logic        checksum_ok;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic       acc_step;   // acc = acc*58 + digit
    logic       acc_clear;
    logic       sha_start;  // load block and initial hash
    logic       sha_round;
    logic       sha_final;  // add feed-forward
    logic       pass2;      // second pass uses first digest
    logic [5:0] round;
  } dp_cmd_t;

  localparam logic [31:0] ShaH0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [5:0] b58_digit(input logic [7:0] c);
    logic [5:0] d;
    d = 6'd0;
    if (c >= "1" && c <= "9") d = 6'(c - 8'd49);
    else if (c >= "A" && c <= "H") d = 6'(c - 8'd56);
    else if (c >= "J" && c <= "N") d = 6'(c - 8'd57);
    else if (c >= "P" && c <= "Z") d = 6'(c - 8'd58);
    else if (c >= "a" && c <= "k") d = 6'(c - 8'd64);
    else if (c >= "m" && c <= "z") d = 6'(c - 8'd65);
    return d;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: rtl/core/b58_datapath.sv
`timescale 1ns / 1ps
module b58_datapath
  import b58_pkg::*;
(
  input  logic       clk,
  input  dp_cmd_t    cmd,
  input  logic [7:0] char_code,
  output out_word_t  result
);

  logic [AccW-1:0] acc;
  logic [31:0]     w [16];
  logic [31:0]     hv [8];
  logic [31:0]     a [8];
  logic [255:0]    blk1;
  logic [255:0]    blk2;
  logic [31:0]     s0, s1, wn, big1, big0, chv, mj, t1, t2;
  logic [AccW+5:0] prod;

  // 256x6 constant multiply: shift-and-add by 58 = 64 - 4 - 2
  assign prod = ({6'd0, acc} << 6) - ({6'd0, acc} << 2) - ({6'd0, acc} << 1)
              + {{AccW{1'b0}}, b58_digit(char_code)};

  // padded message blocks (first 8 words; rest derived in load)
  assign blk1 = {acc[199:32], 8'h80, 80'd0};
  assign blk2 = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};

  always_comb begin
    s0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn   = w[0] + s0 + w[9] + s1;
    big1 = rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25);
    chv  = (a[4] & a[5]) ^ (~a[4] & a[6]);
    t1   = a[7] + big1 + chv + ShaK[cmd.round] + w[0];
    big0 = rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22);
    mj   = (a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]);
    t2   = big0 + mj;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_step) begin
      acc <= prod[AccW-1:0];
    end
    if (cmd.sha_start) begin
      for (int i = 0; i < 8; i++) begin
        w[i] <= cmd.pass2 ? blk2[255-32*i -: 32] : blk1[255-32*i -: 32];
        hv[i] <= ShaH0[i];
        a[i]  <= ShaH0[i];
      end
      for (int i = 8; i < 15; i++) begin
        w[i] <= (cmd.pass2 && i == 8) ? 32'h80000000 : 32'd0;
      end
      w[15] <= cmd.pass2 ? 32'd256 : 32'd168;
    end else if (cmd.sha_round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wn;
      a[7] <= a[6];
      a[6] <= a[5];
      a[5] <= a[4];
      a[4] <= a[3] + t1;
      a[3] <= a[2];
      a[2] <= a[1];
      a[1] <= a[0];
      a[0] <= t1 + t2;
    end else if (cmd.sha_final) begin
      for (int i = 0; i < 8; i++) begin
        hv[i] <= hv[i] + a[i];
      end
    end
  end

  assign result.version_byte  = acc[199:192];
  assign result.hash_word_hi  = acc[191:160];
  assign result.hash_word_mid = acc[159:96];
  assign result.hash_word_lo  = acc[95:32];
  assign result.checksum_ok   = (hv[0] == acc[31:0]);

endmodule

FILE: rtl/core/b58_ctrl.sv
`timescale 1ns / 1ps
module b58_ctrl
  import b58_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    last_char,
  input  logic    out_stall,
  output logic    in_stall,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {IDLE, LOAD, ROUND, FINAL, HOLD} state_t;

  state_t     state;
  logic       pass2;
  logic [5:0] round;
  logic       take;

  assign in_stall = (state != IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.round     = round;
    cmd.pass2     = pass2;
    cmd.acc_step  = take;
    cmd.sha_start = (state == LOAD);
    cmd.sha_round = (state == ROUND);
    cmd.sha_final = (state == FINAL);
    // accumulator clears on reset and when the result word leaves
    cmd.acc_clear = rst || ((state == HOLD) && !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pass2     <= 1'b0;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (take && last_char) begin
            state <= LOAD;
            pass2 <= 1'b0;
          end
        end
        LOAD: begin
          round <= '0;
          state <= ROUND;
        end
        ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= FINAL;
        end
        FINAL: begin
          if (pass2) begin
            state     <= HOLD;
            out_valid <= 1'b1;
          end else begin
            pass2 <= 1'b1;
            state <= LOAD;
          end
        end
        HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == HOLD) else $error("valid outside hold");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> !take) else $error("word taken while busy");
  a_round_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ROUND && round == 6'd63) |=> state == FINAL) else $error("round count");

endmodule

FILE: rtl/core/base58check_address_decode.sv
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_data  (char_code, last_char)
// out     | out_valid | out_stall | out_data (version, hash, checksum_ok)
// Character words are taken while idle. The last one starts two SHA-256
// passes on one shared round unit, then the result waits in a hold
// register until taken; the accumulator clears when it leaves.
// Reset (rst, synchronous) clears control state and the accumulator.
module base58check_address_decode
  import b58_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  dp_cmd_t cmd;

  b58_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .last_char(in_data.last_char),
    .out_stall(out_stall), .in_stall(in_stall), .out_valid(out_valid), .cmd(cmd));

  b58_datapath u_dp (
    .clk(clk), .cmd(cmd), .char_code(in_data.char_code), .result(out_data));

endmodule
